// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/core/dili_pkg.sv -----
// ----------------------------------------------------------------------------
// dili_pkg
// Types and constants of the init list interpreter.
// ----------------------------------------------------------------------------
package dili_pkg;

  localparam logic [7:0] DELAY_FLAG_MASK = 8'h80;
  localparam logic [7:0] LONG_DELAY_CODE = 8'd255;
  localparam logic [8:0] LONG_DELAY_MS   = 9'd500;
  localparam logic [7:0] ACCESS_CTRL_CMD = 8'h36;

  localparam logic KIND_BUS   = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_CMD   = 6'b000010,
    PH_ARGC  = 6'b000100,
    PH_ARGS  = 6'b001000,
    PH_DELAY = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    SEL_FIRST     = 3'b001,
    SEL_TAIL_CMD  = 3'b010,
    SEL_TAIL_DATA = 3'b100
  } sel_t;

  // work for the back end caused by one list byte
  typedef struct packed {
    logic       has_first;
    logic       kind;
    logic [7:0] bus_byte;
    logic       is_data;
    logic       frame_begin;
    logic       frame_end;
    logic [8:0] delay_ms;
    logic       tail;
  } job_t;

  function automatic logic [7:0] orient_byte(input logic [1:0] rot);
    logic [7:0] b;
    unique case (rot)
      2'd0:    b = 8'hC0;
      2'd1:    b = 8'hA0;
      2'd2:    b = 8'h00;
      default: b = 8'h60;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/display_init_list_interpreter_unit.sv -----
// ----------------------------------------------------------------------------
// display_init_list_interpreter_unit
// Turns a display init command list into bus words and delay requests.
// ----------------------------------------------------------------------------
// One list byte is taken per clock while the job queue has room; the parser
// decides everything about a byte in that cycle. The emitter puts out one
// word per clock while out_stall is low; a byte causes none, one, two words
// (orientation command and data after a zero count) or three (last word of
// the list plus the orientation command and data). The emitter's one word a
// cycle, held off by out_stall, sets the sustained rate. Rotation is read as
// the trailing data word is loaded, so write it only while the block is idle.
`include "assert_macros.svh"

module display_init_list_interpreter_unit
  import dili_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] list_byte,
  input  logic       list_start,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] bus_byte,
  output logic       is_data,
  output logic       frame_begin,
  output logic       frame_end,
  output logic [8:0] delay_ms,
  output logic       list_done,
  output logic       last
);

  logic [1:0] rotation;
  logic       take, q_push, q_pop, q_valid, q_full;
  job_t       f_job, q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rotation <= cfg_data;
    end
  end

  dili_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .list_byte  (list_byte),
    .list_start (list_start),
    .job        (f_job),
    .push       (q_push)
  );

  dili_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (f_job),
    .pop    (q_pop),
    .rd_job (q_head),
    .valid  (q_valid),
    .full   (q_full)
  );

  dili_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_valid  (q_valid),
    .rotation    (rotation),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .bus_byte    (bus_byte),
    .is_data     (is_data),
    .frame_begin (frame_begin),
    .frame_end   (frame_end),
    .delay_ms    (delay_ms),
    .list_done   (list_done),
    .last        (last)
  );

  `ASSERT_NEVER(a_queue_overflow, q_push && q_full && !q_pop, "job pushed into full queue")
  `ASSERT_NEVER(a_queue_underflow, q_pop && !q_valid, "job popped from empty queue")
  `ASSERT_AT(a_done_is_last, out_valid && list_done |-> last && is_data && frame_end, "list_done word not final data word")
  `ASSERT_AT(a_delay_clean, out_valid && kind |-> bus_byte == 8'd0 && !frame_begin && !frame_end, "delay word carries bus fields")

endmodule

// ----- rtl/core/dili_front.sv -----
// ----------------------------------------------------------------------------
// dili_front
// List parser: tracks the position in the list and turns each byte that causes work into a job.
// ----------------------------------------------------------------------------
module dili_front
  import dili_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] list_byte,
  input  logic       list_start,
  output job_t       job,
  output logic       push
);

  phase_t     phase, phase_next;
  logic [7:0] commands_left, commands_left_next;
  logic [6:0] args_left, args_left_next;
  logic [7:0] held_command, held_command_next;
  logic       delay_follows, delay_follows_next;

  phase_t     ph;
  logic [7:0] cmd_dec;
  logic [6:0] arg_dec;
  logic       fin;

  always_comb begin
    ph                 = list_start ? PH_COUNT : phase;
    cmd_dec            = commands_left - 8'd1;
    arg_dec            = args_left - 7'd1;
    fin                = 1'b0;
    phase_next         = ph;
    commands_left_next = commands_left;
    args_left_next     = args_left;
    held_command_next  = held_command;
    delay_follows_next = delay_follows;
    job                = '0;

    unique case (ph)
      PH_COUNT: begin
        commands_left_next = list_byte;
        args_left_next     = '0;
        delay_follows_next = 1'b0;
        if (list_byte == 8'd0) begin
          job.tail   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_CMD;
        end
      end
      PH_CMD: begin
        held_command_next = list_byte;
        phase_next        = PH_ARGC;
      end
      PH_ARGC: begin
        delay_follows_next = (list_byte & DELAY_FLAG_MASK) != 8'd0;
        args_left_next     = list_byte[6:0];
        job.has_first      = 1'b1;
        job.kind           = KIND_BUS;
        job.bus_byte       = held_command;
        job.frame_begin    = 1'b1;
        job.frame_end      = list_byte[6:0] == 7'd0;
        if (list_byte[6:0] != 7'd0) begin
          phase_next = PH_ARGS;
        end else if (list_byte[7]) begin
          phase_next = PH_DELAY;
        end else begin
          fin = 1'b1;
        end
      end
      PH_ARGS: begin
        args_left_next = arg_dec;
        job.has_first  = 1'b1;
        job.kind       = KIND_BUS;
        job.bus_byte   = list_byte;
        job.is_data    = 1'b1;
        job.frame_end  = arg_dec == 7'd0;
        if (arg_dec == 7'd0) begin
          if (delay_follows) begin
            phase_next = PH_DELAY;
          end else begin
            fin = 1'b1;
          end
        end
      end
      PH_DELAY: begin
        job.has_first      = 1'b1;
        job.kind           = KIND_DELAY;
        job.delay_ms       = (list_byte == LONG_DELAY_CODE) ? LONG_DELAY_MS
                                                            : {1'b0, list_byte};
        delay_follows_next = 1'b0;
        fin                = 1'b1;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (fin) begin
      commands_left_next = cmd_dec;
      if (cmd_dec == 8'd0) begin
        job.tail   = 1'b1;
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_CMD;
      end
    end
  end

  assign push = take && (job.has_first || job.tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      commands_left <= '0;
      args_left     <= '0;
      held_command  <= '0;
      delay_follows <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      commands_left <= commands_left_next;
      args_left     <= args_left_next;
      held_command  <= held_command_next;
      delay_follows <= delay_follows_next;
    end
  end

endmodule

// ----- rtl/core/dili_queue.sv -----
// ----------------------------------------------------------------------------
// dili_queue
// Small register FIFO of jobs between parser and emitter.
// ----------------------------------------------------------------------------
module dili_queue
  import dili_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic valid,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign valid  = count != '0;
  assign full   = count == CW'(DEPTH);
  assign rd_job = slots[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/dili_back.sv -----
// ----------------------------------------------------------------------------
// dili_back
// Emitter: expands each job into its words and holds them in the output register.
// ----------------------------------------------------------------------------
module dili_back
  import dili_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       head_valid,
  input  logic [1:0] rotation,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] bus_byte,
  output logic       is_data,
  output logic       frame_begin,
  output logic       frame_end,
  output logic [8:0] delay_ms,
  output logic       list_done,
  output logic       last
);

  sel_t       sel, sel_eff;
  logic       load;
  logic       r_kind, r_data, r_fb, r_fe, r_done, r_last;
  logic [7:0] r_byte;
  logic [8:0] r_ms;
  sel_t       sel_after;

  always_comb begin
    sel_eff = (sel == SEL_FIRST && !head.has_first) ? SEL_TAIL_CMD : sel;
    r_kind  = KIND_BUS;
    r_byte  = '0;
    r_data  = 1'b0;
    r_fb    = 1'b0;
    r_fe    = 1'b0;
    r_ms    = '0;
    r_done  = 1'b0;
    r_last  = 1'b1;
    sel_after = SEL_FIRST;
    unique case (sel_eff)
      SEL_FIRST: begin
        r_kind    = head.kind;
        r_byte    = head.bus_byte;
        r_data    = head.is_data;
        r_fb      = head.frame_begin;
        r_fe      = head.frame_end;
        r_ms      = head.delay_ms;
        r_last    = !head.tail;
        sel_after = SEL_TAIL_CMD;
      end
      SEL_TAIL_CMD: begin
        r_byte    = ACCESS_CTRL_CMD;
        r_fb      = 1'b1;
        r_last    = 1'b0;
        sel_after = SEL_TAIL_DATA;
      end
      SEL_TAIL_DATA: begin
        r_byte = orient_byte(rotation);
        r_data = 1'b1;
        r_fe   = 1'b1;
        r_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign load = !out_valid || !out_stall;
  assign pop  = load && head_valid && r_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= SEL_FIRST;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        sel <= r_last ? SEL_FIRST : sel_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      kind        <= r_kind;
      bus_byte    <= r_byte;
      is_data     <= r_data;
      frame_begin <= r_fb;
      frame_end   <= r_fe;
      delay_ms    <= r_ms;
      list_done   <= r_done;
      last        <= r_last;
    end
  end

endmodule

// ----- bench/display_init_list_interpreter_unit_test.sv -----
// ----------------------------------------------------------------------------
// display_init_list_interpreter_unit_test
// Self-checking bench for the init list interpreter: directed lists, then
// random lists with restarts and trailing noise, under bursty input, random
// output stall and one long output hold-off. Every rotation value is used.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module display_init_list_interpreter_unit_test;
  import dili_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [7:0] ORIENT_BYTE [4] = '{8'hC0, 8'hA0, 8'h00, 8'h60};

  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } list_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] bus_byte;
    logic       is_data;
    logic       frame_begin;
    logic       frame_end;
    logic [8:0] delay_ms;
    logic       list_done;
    logic       last;
  } word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] list_byte = 8'd0;
  logic       list_start = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] bus_byte;
  logic       is_data;
  logic       frame_begin;
  logic       frame_end;
  logic [8:0] delay_ms;
  logic       list_done;
  logic       last;

  list_item_t pending_bytes[$];
  word_t      expected_words[$];
  word_t      step_words[$];

  // predictor state
  phase_t     parse_phase = PH_COUNT;
  logic [7:0] cmds_left = 8'd0;
  logic [6:0] args_left = 7'd0;
  logic [7:0] held_cmd = 8'd0;
  logic       delay_pending = 1'b0;
  logic [1:0] rotation_q = 2'd0;

  bit word_taken = 1'b0;
  bit hold_request = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int queued_items = 0;

  display_init_list_interpreter_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .list_byte   (list_byte),
    .list_start  (list_start),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .bus_byte    (bus_byte),
    .is_data     (is_data),
    .frame_begin (frame_begin),
    .frame_end   (frame_end),
    .delay_ms    (delay_ms),
    .list_done   (list_done),
    .last        (last)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  task automatic add_word(input logic k, input logic [7:0] b, input logic d,
                          input logic fb, input logic fe, input logic [8:0] ms,
                          input logic done);
    word_t w;
    w.kind        = k;
    w.bus_byte    = b;
    w.is_data     = d;
    w.frame_begin = fb;
    w.frame_end   = fe;
    w.delay_ms    = ms;
    w.list_done   = done;
    w.last        = 1'b0;
    step_words.push_back(w);
  endtask

  task automatic add_orientation();
    add_word(KIND_BUS, ACCESS_CTRL_CMD, 1'b0, 1'b1, 1'b0, 9'd0, 1'b0);
    add_word(KIND_BUS, ORIENT_BYTE[rotation_q], 1'b1, 1'b0, 1'b1, 9'd0, 1'b1);
    parse_phase = PH_DONE;
  endtask

  task automatic end_command();
    cmds_left = cmds_left - 8'd1;
    if (cmds_left == 8'd0) add_orientation();
    else parse_phase = PH_CMD;
  endtask

  task automatic interpret_byte(input logic [7:0] b, input logic s);
    word_t w;
    step_words.delete();
    if (s) parse_phase = PH_COUNT;
    case (parse_phase)
      PH_COUNT: begin
        cmds_left = b;
        args_left = 7'd0;
        delay_pending = 1'b0;
        if (b == 8'd0) add_orientation();
        else parse_phase = PH_CMD;
      end
      PH_CMD: begin
        held_cmd = b;
        parse_phase = PH_ARGC;
      end
      PH_ARGC: begin
        delay_pending = (b & DELAY_FLAG_MASK) != 8'd0;
        args_left = b[6:0];
        add_word(KIND_BUS, held_cmd, 1'b0, 1'b1, args_left == 7'd0, 9'd0, 1'b0);
        if (args_left != 7'd0) parse_phase = PH_ARGS;
        else if (delay_pending) parse_phase = PH_DELAY;
        else end_command();
      end
      PH_ARGS: begin
        args_left = args_left - 7'd1;
        add_word(KIND_BUS, b, 1'b1, 1'b0, args_left == 7'd0, 9'd0, 1'b0);
        if (args_left == 7'd0) begin
          if (delay_pending) parse_phase = PH_DELAY;
          else end_command();
        end
      end
      PH_DELAY: begin
        add_word(KIND_DELAY, 8'd0, 1'b0, 1'b0, 1'b0,
                 (b == LONG_DELAY_CODE) ? LONG_DELAY_MS : {1'b0, b}, 1'b0);
        delay_pending = 1'b0;
        end_command();
      end
      default: ;
    endcase
    foreach (step_words[i]) begin
      w = step_words[i];
      w.last = (i == step_words.size() - 1);
      expected_words.push_back(w);
    end
  endtask

  function automatic string word_text(input word_t w);
    return $sformatf("kind=%0d byte=%02h dc=%0d fb=%0d fe=%0d ms=%0d done=%0d last=%0d",
                     w.kind, w.bus_byte, w.is_data, w.frame_begin, w.frame_end,
                     w.delay_ms, w.list_done, w.last);
  endfunction

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (rst) begin
      word_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind, bus_byte, is_data, frame_begin, frame_end, delay_ms, list_done, last};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, got %s", $time, word_text(got));
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: word mismatch: expected %s, got %s", $time,
                     word_text(want), word_text(got));
            error_count++;
          end
        end
      end
      word_taken = in_valid && !in_stall;
      if (word_taken) interpret_byte(list_byte, list_start);
    end
  end

  // ------------------------------------------------------------------- driver
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    list_item_t item;
    if (!rst && (!in_valid || word_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        item = pending_bytes.pop_front();
        in_valid   <= 1'b1;
        list_byte  <= item.value;
        list_start <= item.start;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 10);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  int hold_left = 0;
  bit hold_started = 1'b0;
  int mode_left = 0;
  int stall_pct = 0;

  always @(negedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(4, 60);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b, input logic s);
    pending_bytes.push_back('{value: b, start: s});
    queued_items++;
  endtask

  task automatic queue_random_list(input bit long_args);
    int n_cmds;
    int n_args;
    int cut;
    int pos;
    int r;
    logic flag;
    n_cmds = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
    if (long_args) n_cmds = 1;
    // a cut list is followed by a new start, i.e. a restart mid-list
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 100000;
    push_byte(8'(n_cmds), 1'b1);
    pos = 1;
    for (int c = 0; c < n_cmds; c++) begin
      if (pos >= cut) break;
      push_byte(8'($urandom_range(0, 255)), 1'b0);
      pos++;
      if (pos >= cut) break;
      n_args = long_args ? 127 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
      flag = long_args ? 1'b1 : 1'($urandom_range(0, 1));
      push_byte({flag, 7'(n_args)}, 1'b0);
      pos++;
      for (int a = 0; a < n_args; a++) begin
        if (pos >= cut) break;
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        pos++;
      end
      if (pos >= cut) break;
      if (flag) begin
        r = $urandom_range(0, 5);
        push_byte((r == 0) ? 8'd0 : (r == 1) ? LONG_DELAY_CODE : 8'($urandom_range(0, 255)),
                  1'b0);
        pos++;
      end
    end
    // bytes after completion are ignored
    if (pos < cut && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2))
        pending_bytes.push_back('{value: 8'($urandom_range(0, 255)), start: 1'b0});
    end
  endtask

  task automatic write_rotation(input logic [1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rotation_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_rotation(2'd3);
    // first count byte straight after reset, without a start mark
    push_byte(8'd1, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'd0, 1'b1);
    pending_bytes.push_back('{value: 8'hAA, start: 1'b0});
    pending_bytes.push_back('{value: 8'h55, start: 1'b0});
    push_byte(8'd2, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h3A, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'd1, 1'b1);
    push_byte(8'h2C, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'd1, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'd0, 1'b1);
    drain();

    write_rotation(2'd0);
    queued_items = 0;
    queue_random_list(1'b1);
    while (queued_items < 170) queue_random_list(1'b0);
    drain();

    write_rotation(2'd2);
    queued_items = 0;
    while (queued_items < 80) queue_random_list(1'b0);
    hold_request = 1'b1;
    drain();

    write_rotation(2'd1);
    queued_items = 0;
    while (queued_items < 80) queue_random_list(1'b0);
    drain();

    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
